FILE: rtl/dbff_pkg.sv
`timescale 1ns / 1ps

package dbff_pkg;

   // Field widths of the request, response and register words.
   localparam int OP_W          = 3;
   localparam int PIXEL_X_W     = 8;
   localparam int PIXEL_Y_W     = 7;
   localparam int BYTE_W        = 8;
   localparam int BLOCK_INDEX_W = 6;
   localparam int OFFSET_W      = 4;

   // Shift used by the reciprocal multipliers that replace small divisions.
   localparam int RECIP_SHIFT = 16;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_SET    = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
   localparam logic [OP_W-1:0] OP_TOGGLE = 3'd2;
   localparam logic [OP_W-1:0] OP_READ   = 3'd3;
   localparam logic [OP_W-1:0] OP_FILL   = 3'd4;
   localparam logic [OP_W-1:0] OP_FLUSH  = 3'd5;

   // Display link command bytes.
   localparam logic [BYTE_W-1:0] PAGE_CMD     = 8'hB0;
   localparam logic [BYTE_W-1:0] COL_HIGH_CMD = 8'h10;
   localparam logic [BYTE_W-1:0] NIBBLE_MASK  = 8'h0F;

   // Response kinds.
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_LINK  = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic [PIXEL_X_W-1:0]     pixel_x;
      logic [PIXEL_Y_W-1:0]     pixel_y;
      logic [BYTE_W-1:0]        fill_value;
      logic [BLOCK_INDEX_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic              result_kind;
      logic              pixel_value;
      logic [BYTE_W-1:0] link_byte;
      logic              is_data;
      logic              is_last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic sweep_rst;
      logic clear_step;
      logic fill_step;
      logic pix_reply;
      logic fl_page;
      logic fl_first;
      logic fl_cmd;
      logic fl_read;
      logic fl_data;
   } ctl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic out_free;
      logic sweep_last;
      logic flush_ok;
      logic cmd_last;
      logic data_last;
   } ctl_sts_type;

endpackage

FILE: rtl/dbff_ifs.sv
`timescale 1ns / 1ps

interface dbff_req_if
   import dbff_pkg::*;
   ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface dbff_rsp_if
   import dbff_pkg::*;
   ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface dbff_csr_if
   import dbff_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/dbff_ctrl.sv
`timescale 1ns / 1ps

module dbff_ctrl
   import dbff_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_op,
   output logic            req_ready,
   output ctl_cmd_type     cmd,
   input  ctl_sts_type     sts
);

   typedef enum logic [9:0] {
      S_CLEAR = 10'b00_0000_0001,
      S_IDLE  = 10'b00_0000_0010,
      S_PIX   = 10'b00_0000_0100,
      S_FILL  = 10'b00_0000_1000,
      S_FEND  = 10'b00_0001_0000,
      S_FS1   = 10'b00_0010_0000,
      S_FS2   = 10'b00_0100_0000,
      S_FCMD  = 10'b00_1000_0000,
      S_FREAD = 10'b01_0000_0000,
      S_FDATA = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_op == OP_SET || req_op == OP_CLEAR ||
                   req_op == OP_TOGGLE || req_op == OP_READ) begin
                  state_in = S_PIX;
               end else if (req_op == OP_FILL) begin
                  cmd.sweep_rst = 1'b1;
                  state_in      = S_FILL;
               end else if (req_op == OP_FLUSH) begin
                  state_in = S_FS1;
               end
            end
         end
         S_PIX: begin
            if (sts.out_free) begin
               cmd.pix_reply = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_FEND;
            end
         end
         S_FEND: begin
            // The last fill byte is compared and written in this cycle.
            state_in = S_PIX;
         end
         S_FS1: begin
            cmd.fl_page = 1'b1;
            state_in    = sts.flush_ok ? S_FS2 : S_IDLE;
         end
         S_FS2: begin
            cmd.fl_first = 1'b1;
            state_in     = S_FCMD;
         end
         S_FCMD: begin
            if (sts.out_free) begin
               cmd.fl_cmd = 1'b1;
               if (sts.cmd_last) begin
                  state_in = S_FREAD;
               end
            end
         end
         S_FREAD: begin
            cmd.fl_read = 1'b1;
            state_in    = S_FDATA;
         end
         S_FDATA: begin
            if (sts.out_free) begin
               cmd.fl_data = 1'b1;
               state_in    = sts.data_last ? S_IDLE : S_FREAD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // A response is loaded only when the output register can take it.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.pix_reply || cmd.fl_cmd || cmd.fl_data) |-> sts.out_free)
      else $error("response loaded into a full output register");

   // A new request is never taken while a response source is active.
   a_accept_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !(cmd.pix_reply || cmd.fl_cmd || cmd.fl_data || cmd.fill_step))
      else $error("request accepted during another operation");

endmodule

FILE: rtl/dbff_datapath.sv
`timescale 1ns / 1ps

module dbff_datapath
   import dbff_pkg::*;
#(
   parameter int SCREEN_WIDTH      = 128,
   parameter int SCREEN_HEIGHT     = 64,
   parameter int COLUMNS_PER_BLOCK = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  req_type             req_data,
   input  logic                csr_we,
   input  logic [OFFSET_W-1:0] csr_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output rsp_type             rsp_data,
   input  ctl_cmd_type         cmd,
   output ctl_sts_type         sts
);

   localparam int NUM_PAGES   = (SCREEN_HEIGHT + 7) / 8;
   localparam int BPP         = (SCREEN_WIDTH + COLUMNS_PER_BLOCK - 1) / COLUMNS_PER_BLOCK;
   localparam int NUM_BLOCKS  = NUM_PAGES * BPP;
   localparam int MARK_LIMIT  = 1 << BLOCK_INDEX_W;
   localparam int DIRTY_N     = (NUM_BLOCKS < MARK_LIMIT) ? NUM_BLOCKS : MARK_LIMIT;
   localparam int STORE_BYTES = NUM_PAGES * SCREEN_WIDTH;
   localparam int AW          = $clog2(STORE_BYTES);
   localparam int CW          = $clog2(SCREEN_WIDTH);
   localparam int KW          = (COLUMNS_PER_BLOCK > 1) ? $clog2(COLUMNS_PER_BLOCK) : 1;
   localparam int BKW         = $clog2(NUM_BLOCKS + 1);
   localparam int DW          = (DIRTY_N > 1) ? $clog2(DIRTY_N) : 1;
   localparam int DMARK_N     = 1 << DW;
   localparam int PW          = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int RX          = ((1 << RECIP_SHIFT) + COLUMNS_PER_BLOCK - 1) / COLUMNS_PER_BLOCK;
   localparam int RB          = ((1 << RECIP_SHIFT) + BPP - 1) / BPP;

   logic [BYTE_W-1:0]   mem [STORE_BYTES];
   logic                dmark [DMARK_N];
   req_type             fld_ff;
   logic [BYTE_W-1:0]   rd_ff;
   logic                dmark_rd_ff;
   logic [OFFSET_W-1:0] coloff_ff;
   logic [AW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [KW-1:0]       cib_ff, cib_in;
   logic [BKW-1:0]      bk_ff, bk_in;
   logic                st_v_ff;
   logic [AW-1:0]       st_addr_ff;
   logic [BKW-1:0]      st_bk_ff;
   logic [PW-1:0]       page_ff;
   logic [1:0]          cidx_ff, cidx_in;
   logic                out_v_ff, out_v_in;
   rsp_type             out_ff, out_in;

   logic [15:0]         req_addr, pix_addr, pix_blk, fl_addr, fl_first;
   logic [31:0]         pix_quot, fl_prod;
   logic                in_screen, is_pix_op, old_bit, changed, pix_wr, fill_diff;
   logic [BYTE_W-1:0]   mask, new_byte, cmd_byte;
   logic                mem_we, mem_re;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   logic [BYTE_W-1:0]   mem_wdata;
   logic                dmark_we, dmark_wdata;
   logic [DW-1:0]       dmark_waddr;
   logic                sweep_adv;

   // Pixel address of an incoming request, read at the accept edge.
   assign req_addr = 16'(req_data.pixel_y >> 3) * 16'(SCREEN_WIDTH) + 16'(req_data.pixel_x);

   // Pixel read-modify-write on the latched request.
   assign pix_addr  = 16'(fld_ff.pixel_y >> 3) * 16'(SCREEN_WIDTH) + 16'(fld_ff.pixel_x);
   assign pix_quot  = (32'(fld_ff.pixel_x) * 32'(RX)) >> RECIP_SHIFT;
   assign pix_blk   = 16'(fld_ff.pixel_y >> 3) * 16'(BPP) + 16'(pix_quot);
   assign in_screen = (16'(fld_ff.pixel_x) < 16'(SCREEN_WIDTH)) &&
                      (16'(fld_ff.pixel_y) < 16'(SCREEN_HEIGHT));
   assign is_pix_op = (fld_ff.operation == OP_SET) || (fld_ff.operation == OP_CLEAR) ||
                      (fld_ff.operation == OP_TOGGLE) || (fld_ff.operation == OP_READ);
   assign mask      = 8'(1) << fld_ff.pixel_y[2:0];
   assign old_bit   = |(rd_ff & mask);

   always_comb begin
      new_byte = rd_ff;
      changed  = 1'b0;
      case (fld_ff.operation)
         OP_SET: begin
            new_byte = rd_ff | mask;
            changed  = !old_bit;
         end
         OP_CLEAR: begin
            new_byte = rd_ff & ~mask;
            changed  = old_bit;
         end
         OP_TOGGLE: begin
            new_byte = rd_ff ^ mask;
            changed  = 1'b1;
         end
         default: begin
            new_byte = rd_ff;
            changed  = 1'b0;
         end
      endcase
   end

   assign pix_wr    = cmd.pix_reply && in_screen && changed;
   assign fill_diff = st_v_ff && (rd_ff != fld_ff.fill_value);

   // Flush address math: page by reciprocal, then first column.
   assign fl_prod  = 32'(fld_ff.block_index) * 32'(RB);
   assign fl_first = 16'(fld_ff.block_index) * 16'(COLUMNS_PER_BLOCK) -
                     16'(page_ff) * 16'(BPP * COLUMNS_PER_BLOCK);
   assign fl_addr  = 16'(page_ff) * 16'(SCREEN_WIDTH) + 16'(col_ff);

   always_comb begin
      case (cidx_ff)
         2'd0:    cmd_byte = PAGE_CMD | 8'(page_ff);
         2'd1:    cmd_byte = (8'(col_ff) & NIBBLE_MASK) | 8'(coloff_ff);
         default: cmd_byte = COL_HIGH_CMD | ((8'(col_ff) >> 4) & NIBBLE_MASK);
      endcase
   end

   assign sts.out_free   = !out_v_ff || rsp_ready;
   assign sts.sweep_last = (cnt_ff == AW'(STORE_BYTES - 1));
   assign sts.flush_ok   = (16'(fld_ff.block_index) < 16'(DIRTY_N)) && dmark_rd_ff;
   assign sts.cmd_last   = (cidx_ff == 2'd2);
   assign sts.data_last  = (cib_ff == KW'(COLUMNS_PER_BLOCK - 1)) ||
                           (col_ff == CW'(SCREEN_WIDTH - 1));

   // Memory port selection.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = '0;
      if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (fill_diff) begin
         mem_we    = 1'b1;
         mem_waddr = st_addr_ff;
         mem_wdata = fld_ff.fill_value;
      end else if (pix_wr) begin
         mem_we    = 1'b1;
         mem_waddr = AW'(pix_addr);
         mem_wdata = new_byte;
      end
   end

   assign mem_re = cmd.accept || cmd.fill_step || cmd.fl_read;

   always_comb begin
      if (cmd.accept) begin
         mem_raddr = AW'(req_addr);
      end else if (cmd.fill_step) begin
         mem_raddr = cnt_ff;
      end else begin
         mem_raddr = AW'(fl_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_ff <= mem[mem_raddr];
      end
   end

   // Dirty marks live in a small memory with one write and one registered
   // read. The clearing pass after reset sets every mark; the mark of a
   // flush request is read at its accept edge.
   always_comb begin
      dmark_we    = 1'b0;
      dmark_waddr = cnt_ff[DW-1:0];
      dmark_wdata = 1'b1;
      if (cmd.clear_step) begin
         dmark_we = (32'(cnt_ff) < 32'(DIRTY_N));
      end else if (fill_diff) begin
         dmark_we    = (st_bk_ff < BKW'(DIRTY_N));
         dmark_waddr = st_bk_ff[DW-1:0];
      end else if (pix_wr) begin
         dmark_we    = (pix_blk < 16'(DIRTY_N));
         dmark_waddr = pix_blk[DW-1:0];
      end else if (cmd.fl_first) begin
         dmark_we    = 1'b1;
         dmark_waddr = fld_ff.block_index[DW-1:0];
         dmark_wdata = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dmark_we) begin
         dmark[dmark_waddr] <= dmark_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         dmark_rd_ff <= dmark[req_data.block_index[DW-1:0]];
      end
   end

   // Sweep and column counters, shared by clear, fill and flush.
   assign sweep_adv = cmd.clear_step || cmd.fill_step;

   always_comb begin
      cnt_in = cnt_ff;
      col_in = col_ff;
      cib_in = cib_ff;
      bk_in  = bk_ff;
      if (cmd.sweep_rst) begin
         cnt_in = '0;
         col_in = '0;
         cib_in = '0;
         bk_in  = '0;
      end else if (sweep_adv) begin
         cnt_in = cnt_ff + AW'(1);
         if (col_ff == CW'(SCREEN_WIDTH - 1)) begin
            col_in = '0;
            cib_in = '0;
            bk_in  = bk_ff + BKW'(1);
         end else if (cib_ff == KW'(COLUMNS_PER_BLOCK - 1)) begin
            col_in = col_ff + CW'(1);
            cib_in = '0;
            bk_in  = bk_ff + BKW'(1);
         end else begin
            col_in = col_ff + CW'(1);
            cib_in = cib_ff + KW'(1);
         end
      end else if (cmd.fl_first) begin
         col_in = CW'(fl_first);
         cib_in = '0;
      end else if (cmd.fl_data) begin
         col_in = col_ff + CW'(1);
         cib_in = cib_ff + KW'(1);
      end
   end

   always_comb begin
      cidx_in = cidx_ff;
      if (cmd.fl_first) begin
         cidx_in = '0;
      end else if (cmd.fl_cmd) begin
         cidx_in = cidx_ff + 2'd1;
      end
   end

   // Output register.
   always_comb begin
      out_in   = out_ff;
      out_v_in = out_v_ff && !rsp_ready;
      if (cmd.pix_reply) begin
         out_v_in           = 1'b1;
         out_in.result_kind = KIND_PIXEL;
         out_in.pixel_value = in_screen && is_pix_op && old_bit;
         out_in.link_byte   = '0;
         out_in.is_data     = 1'b0;
         out_in.is_last     = 1'b1;
      end else if (cmd.fl_cmd) begin
         out_v_in           = 1'b1;
         out_in.result_kind = KIND_LINK;
         out_in.pixel_value = 1'b0;
         out_in.link_byte   = cmd_byte;
         out_in.is_data     = 1'b0;
         out_in.is_last     = 1'b0;
      end else if (cmd.fl_data) begin
         out_v_in           = 1'b1;
         out_in.result_kind = KIND_LINK;
         out_in.pixel_value = 1'b0;
         out_in.link_byte   = rd_ff;
         out_in.is_data     = 1'b1;
         out_in.is_last     = sts.data_last;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         col_ff    <= '0;
         cib_ff    <= '0;
         bk_ff     <= '0;
         st_v_ff   <= 1'b0;
         cidx_ff   <= '0;
         out_v_ff  <= 1'b0;
         coloff_ff <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         col_ff   <= col_in;
         cib_ff   <= cib_in;
         bk_ff    <= bk_in;
         st_v_ff  <= cmd.fill_step;
         cidx_ff  <= cidx_in;
         out_v_ff <= out_v_in;
         if (csr_we) begin
            coloff_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (cmd.accept) begin
         fld_ff <= req_data;
      end
      if (cmd.fill_step) begin
         st_addr_ff <= cnt_ff;
         st_bk_ff   <= bk_ff;
      end
      if (cmd.fl_page) begin
         page_ff <= PW'(fl_prod >> RECIP_SHIFT);
      end
   end

   // The fill compare stage only runs on bytes that the sweep has read.
   a_stage_src: assert property (@(posedge clock) disable iff (reset)
      st_v_ff |-> $past(cmd.fill_step))
      else $error("fill stage active without a sweep read");

   // Only one write source drives the memory in any cycle.
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_step, st_v_ff, pix_wr}))
      else $error("conflicting memory writes");

endmodule

FILE: rtl/dirty_block_framebuffer_flush.sv
`timescale 1ns / 1ps

// Page-organized monochrome framebuffer with per-block dirty marks.
// The request channel carries one word per operation: set, clear, toggle
// or read a pixel, fill the whole buffer, or flush one block. Pixel
// operations and fill answer with one pixel reply word on the response
// channel. A flush of a dirty block answers with three command words and
// then the block's data words, the last one flagged; a clean or
// nonexistent block answers with nothing. The register channel sets the
// column offset and is always ready.
// A pixel operation is a read-modify-write on the byte store, whose read
// data is registered. Fill covers NUM_PAGES * SCREEN_WIDTH store bytes,
// one store byte per cycle. A flush reads and sends its data bytes one
// at a time, since every byte is a registered store read before it is sent.
// After reset the store is cleared by a pass over NUM_PAGES * SCREEN_WIDTH
// bytes (1024 with the default size) while no request is accepted; the
// same pass sets every dirty mark. A stalled receiver holds the output
// register; the next request is still taken and waits only when it needs
// to load a new response word.
module dirty_block_framebuffer_flush
   import dbff_pkg::*;
#(
   parameter int SCREEN_WIDTH      = 128,
   parameter int SCREEN_HEIGHT     = 64,
   parameter int COLUMNS_PER_BLOCK = 16
)
(
   input logic        clock,
   input logic        reset,
   dbff_req_if.sink   req_ch,
   dbff_rsp_if.source rsp_ch,
   dbff_csr_if.sink   csr_ch
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // The column offset register takes a write in any cycle.
   assign csr_ch.ready = 1'b1;

   dbff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.data.operation),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   dbff_datapath #(
      .SCREEN_WIDTH      (SCREEN_WIDTH),
      .SCREEN_HEIGHT     (SCREEN_HEIGHT),
      .COLUMNS_PER_BLOCK (COLUMNS_PER_BLOCK)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_ch.data),
      .csr_we    (csr_ch.valid),
      .csr_data  (csr_ch.data),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_data  (rsp_ch.data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
